// File: hdl/sacd_pkg.sv
// sacd_pkg: shared constants and types for the set-associative cache directory.
// No dependencies.
`timescale 1ns / 1ps
package sacd_pkg;
  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_REPORT = 2'd2;

  localparam logic [1:0] POL_RANDOM = 2'd0;
  localparam logic [1:0] POL_LFU    = 2'd1;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_BOB    = 1'b1;

  // Geometry is fixed by the widths of out_set_index and out_way.
  localparam int NUM_SETS = 16;
  localparam int NUM_WAYS = 4;

  localparam int ADDR_W = 24;
  localparam int CNT_W  = 32;
  localparam int USE_W  = 4;

  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] addr;
  } req_t;
endpackage

// File: hdl/set_assoc_cache_directory.sv
// set_assoc_cache_directory: top level, tag directory with row memory.
// Depends on sacd_pkg.
`timescale 1ns / 1ps
// Channel  | Direction | Ports                                 | Handshake
// ---------+-----------+---------------------------------------+------------------------
// in       | input     | in_op, in_addr                        | start & !busy
// out      | output    | out_hit .. out_miss_count             | out_valid, one cycle
// cfg      | input     | cfg_we, cfg_index, cfg_data           | cfg_we
//
// A read or write reads the set row from the row memory (registered read)
// and then updates it for all ways and writes it back; a write that hits
// skips the write-back and the counters. Reset: rst_n low resets the
// registers only; a clearing pass then runs with busy high to clear every
// set of the row memory. The receiver cannot stall: results appear for one cycle.
module set_assoc_cache_directory #(
  parameter int EPOCH_LEN = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [23:0] in_addr,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  output logic        out_valid,
  output logic        out_hit,
  output logic [1:0]  out_way,
  output logic [3:0]  out_set_index,
  output logic [23:0] out_fill_addr,
  output logic        out_fill_request,
  output logic [31:0] out_hit_count,
  output logic [31:0] out_miss_count
);
  localparam int NUM_SETS = sacd_pkg::NUM_SETS;
  localparam int NUM_WAYS = sacd_pkg::NUM_WAYS;
  localparam int SW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int WW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int ENT_W = 1 + sacd_pkg::ADDR_W + 1 + sacd_pkg::USE_W;
  localparam int ROW_W = NUM_WAYS * ENT_W;

  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  typedef struct packed {
    logic        v;
    logic [23:0] tag;
    logic        rf;
    logic [3:0]  uc;
  } ent_t;

  logic [ROW_W-1:0] mem [NUM_SETS];
  logic [ROW_W-1:0] rd_q;
  logic [SW-1:0]    rd_a, wr_a;
  logic             wr_en;
  logic [ROW_W-1:0] wr_d;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_a] <= wr_d;
    rd_q <= mem[rd_a];
  end

  logic [1:0]  st_r, st_nxt;
  logic [SW:0] clr_r;
  logic [1:0]  pol_r;
  logic [2:0]  bob_r;
  logic [3:0]  epoch_r;
  logic [15:0] lfsr_r, lfsr_nxt;
  logic [31:0] hits_r, misses_r, hits_nxt, misses_nxt;
  sacd_pkg::req_t req_r;

  logic [23:0] line_w;
  logic [SW-1:0] set_w;
  logic [23:0] tag_w;
  assign line_w = req_r.addr >> bob_r;
  assign set_w  = (NUM_SETS > 1) ? SW'(line_w % NUM_SETS) : '0;
  assign tag_w  = 24'(line_w / NUM_SETS);

  logic [23:0] in_line;
  assign in_line = in_addr >> bob_r;

  assign busy = (st_r != ST_IDLE);

  ent_t row [NUM_WAYS];
  ent_t nrow [NUM_WAYS];
  logic [NUM_WAYS-1:0] match;
  logic found;
  logic [WW-1:0] hit_way, victim;
  logic [3:0] maxc;
  logic taken;
  logic [15:0] lf;
  logic b;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      row[w] = rd_q[w*ENT_W +: ENT_W];
      match[w] = row[w].v && (row[w].tag == tag_w);
    end
    found = |match;
    hit_way = '0;
    for (int w = NUM_WAYS-1; w >= 0; w--) if (match[w]) hit_way = WW'(w);
    for (int w = 0; w < NUM_WAYS; w++) begin
      nrow[w] = row[w];
      if (match[w]) begin
        nrow[w].rf = 1'b0;
        nrow[w].uc = '0;
      end else begin
        nrow[w].rf = 1'b1;
        if (epoch_r < 4'(EPOCH_LEN))
          nrow[w].uc = (row[w].uc != 4'hF) ? row[w].uc + 4'd1 : row[w].uc;
        else nrow[w].uc = '0;
      end
    end
    victim = '0;
    taken = 1'b0;
    lf = lfsr_r;
    maxc = nrow[0].uc;
    lfsr_nxt = lfsr_r;
    if (!found) begin
      if (pol_r == sacd_pkg::POL_RANDOM) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
          b = lf[0] ^ lf[2] ^ lf[3] ^ lf[5];
          lf = {b, lf[15:1]};
          if (!taken && b && nrow[w].rf) begin
            victim = WW'(w);
            taken = 1'b1;
          end
        end
        lfsr_nxt = lf;
        nrow[victim].v = 1'b1;
        nrow[victim].tag = tag_w;
        nrow[victim].rf = 1'b0;
      end else if (pol_r == sacd_pkg::POL_LFU) begin
        for (int w = 0; w < NUM_WAYS; w++)
          if (nrow[w].uc >= maxc) begin
            maxc = nrow[w].uc;
            victim = WW'(w);
          end
        nrow[victim].v = 1'b1;
        nrow[victim].tag = tag_w;
        nrow[victim].uc = '0;
      end else begin
        for (int w = NUM_WAYS-1; w > 0; w--) begin
          nrow[w].v = nrow[w-1].v;
          nrow[w].tag = nrow[w-1].tag;
        end
        nrow[0].v = 1'b1;
        nrow[0].tag = tag_w;
      end
    end
    b = 1'b0;
  end

  logic skip;
  assign skip = found && (req_r.op == sacd_pkg::OP_WRITE);

  always_comb begin
    st_nxt = st_r;
    rd_a = in_line[SW-1:0];
    if (NUM_SETS > 1) rd_a = SW'(in_line % NUM_SETS);
    wr_a = set_w;
    wr_en = 1'b0;
    wr_d = '0;
    for (int w = 0; w < NUM_WAYS; w++) wr_d[w*ENT_W +: ENT_W] = nrow[w];
    hits_nxt = hits_r;
    misses_nxt = misses_r;
    case (st_r)
      ST_CLR: begin
        wr_en = 1'b1;
        wr_a = clr_r[SW-1:0];
        for (int w = 0; w < NUM_WAYS; w++)
          wr_d[w*ENT_W +: ENT_W] = {1'b0, 24'hFFFFFF, 1'b0, 4'd0};
        if (clr_r == (SW+1)'(NUM_SETS-1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          if (in_op == sacd_pkg::OP_READ || in_op == sacd_pkg::OP_WRITE) st_nxt = ST_UPD;
          else if (in_op == sacd_pkg::OP_REPORT) begin
            hits_nxt = '0;
            misses_nxt = '0;
          end
        end
      end
      ST_UPD: begin
        st_nxt = ST_IDLE;
        if (!skip) begin
          wr_en = 1'b1;
          if (found) hits_nxt = (hits_r != '1) ? hits_r + 32'd1 : hits_r;
          else misses_nxt = (misses_r != '1) ? misses_r + 32'd1 : misses_r;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_CLR;
      clr_r <= '0;
      pol_r <= 2'd0;
      bob_r <= 3'd2;
      epoch_r <= '0;
      lfsr_r <= 16'd1;
      hits_r <= '0;
      misses_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      clr_r <= clr_r + 1'b1;
      hits_r <= hits_nxt;
      misses_r <= misses_nxt;
      if (cfg_we) begin
        if (cfg_index == sacd_pkg::CFG_POLICY) pol_r <= cfg_data[1:0];
        else bob_r <= cfg_data;
      end
      out_valid <= 1'b0;
      if (st_r == ST_IDLE && start) begin
        req_r.op <= in_op;
        req_r.addr <= in_addr;
        if (!(in_op == sacd_pkg::OP_READ || in_op == sacd_pkg::OP_WRITE)) begin
          out_valid <= 1'b1;
          out_hit <= 1'b0;
          out_way <= '0;
          out_set_index <= '0;
          out_fill_addr <= '0;
          out_fill_request <= 1'b0;
          out_hit_count <= hits_r;
          out_miss_count <= misses_r;
        end
      end
      if (st_r == ST_UPD) begin
        out_valid <= 1'b1;
        out_hit <= found;
        out_way <= 2'(found ? hit_way : victim);
        out_set_index <= 4'(set_w);
        out_fill_addr <= found ? 24'd0 : 24'(line_w << bob_r);
        out_fill_request <= !found;
        out_hit_count <= hits_nxt;
        out_miss_count <= misses_nxt;
        if (!skip) begin
          epoch_r <= (epoch_r < 4'(EPOCH_LEN)) ? epoch_r + 4'd1 : 4'd0;
          lfsr_r <= lfsr_nxt;
        end
      end
    end
  end

  // A hit never raises a fill request.
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_fill_request) else $error("fill flag");
  // An access result is valid in the cycle after the update state.
  a_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_UPD) |=> out_valid) else $error("missing result");
  // No access is taken during the clearing pass.
  a_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CLR) |-> busy) else $error("busy during clear");
endmodule
